// ===== src/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional array list package
// Shared types, codes and constants for the list controller and datapath.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam logic [6:0] CAP_RESET = 7'd64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [6:0]         position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] found_position;
        logic [6:0] entry_count;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_INS_CHK,
        S_INS_WR,
        S_DEL_CHK,
        S_DEL_WR,
        S_FIND_CHK,
        S_FIND_CMP
    } state_t;

    typedef enum logic [1:0] {
        RD_PREV,
        RD_NEXT,
        RD_CUR
    } rd_sel_t;

    typedef struct packed {
        logic       load;
        logic       idx_load_count;
        logic       idx_load_pos;
        logic       idx_clear;
        logic       idx_inc;
        logic       idx_dec;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       wr_shift;
        logic       wr_val;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_valid;
        logic [1:0] res_status;
        logic       res_found;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       ins_range;
        logic       del_range;
        logic       ins_more;
        logic       del_more;
        logic       find_more;
        logic       hit;
    } dp_stat_t;

endpackage

// ===== src/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// Positional array list
// Ordered list of signed 32-bit values with insert, delete and find requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on result for one cycle with result_valid high and cannot be held
// off, so the receiver must capture it then. Entries sit in a memory, and
// every moved entry is read and then written back, while every searched
// entry is read and then compared. A rejected request or an unused opcode
// is answered from the evaluation state. An insert at position p with n
// entries moves n - p entries up and a delete moves n - p - 1 entries down.
// A find examines entries from position 0 until one matches or all n
// entries have been examined, and reports not found in the latter case.
// Busy drops in the cycle the result is shown. The capacity register takes
// a write while the block is idle; it resets to 64.
module positional_array_list #(
    parameter int DEPTH = pal_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pal_pkg::req_t request,
    output logic          result_valid,
    output pal_pkg::res_t result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [6:0]    cfg_data
);
    import pal_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = !busy;

    pal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    pal_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== src/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// Positional array list controller
// Sequences the checks, shift loops and search loop of one request.
// ----------------------------------------------------------------------------
module pal_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pal_pkg::dp_stat_t stat,
    output pal_pkg::dp_cmd_t  cmd
);
    import pal_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_CUR;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                unique case (stat.op)
                    OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_valid  = 1'b1;
                            cmd.res_status = ST_FULL;
                            state_next     = S_IDLE;
                        end
                        else if (stat.ins_range)
                        begin
                            cmd.res_valid  = 1'b1;
                            cmd.res_status = ST_RANGE;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.idx_load_count = 1'b1;
                            state_next         = S_INS_CHK;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (stat.del_range)
                        begin
                            cmd.res_valid  = 1'b1;
                            cmd.res_status = ST_RANGE;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.idx_load_pos = 1'b1;
                            state_next       = S_DEL_CHK;
                        end
                    end
                    OP_FIND:
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = S_FIND_CHK;
                    end
                    default:
                    begin
                        cmd.res_valid  = 1'b1;
                        cmd.res_status = ST_OK;
                        state_next     = S_IDLE;
                    end
                endcase
            end
            S_INS_CHK:
            begin
                if (stat.ins_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PREV;
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.wr_val     = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    cmd.res_valid  = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_IDLE;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_dec  = 1'b1;
                state_next   = S_INS_CHK;
            end
            S_DEL_CHK:
            begin
                if (stat.del_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = S_DEL_WR;
                end
                else
                begin
                    cmd.cnt_dec    = 1'b1;
                    cmd.res_valid  = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_IDLE;
                end
            end
            S_DEL_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_DEL_CHK;
            end
            S_FIND_CHK:
            begin
                if (stat.find_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    state_next = S_FIND_CMP;
                end
                else
                begin
                    cmd.res_valid  = 1'b1;
                    cmd.res_status = ST_NOTFOUND;
                    state_next     = S_IDLE;
                end
            end
            S_FIND_CMP:
            begin
                if (stat.hit)
                begin
                    cmd.res_valid  = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_found  = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_FIND_CHK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/pal_dp.sv =====
// ----------------------------------------------------------------------------
// Positional array list datapath
// Entry memory, count, capacity register, walk index and result register.
// ----------------------------------------------------------------------------
module pal_dp #(
    parameter int DEPTH = pal_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pal_pkg::req_t     request,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [6:0]        cfg_data,
    input  pal_pkg::dp_cmd_t  cmd,
    output pal_pkg::dp_stat_t stat,
    output logic              result_valid,
    output pal_pkg::res_t     result
);
    import pal_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rdata_reg;
    logic [1:0]    op_reg;
    logic [6:0]    pos_reg;
    logic [31:0]   val_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [6:0]    cap_reg;
    logic          result_valid_reg;
    res_t          result_reg;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] idx_ext;
    logic [CMPW-1:0] count_ext;
    logic [CMPW-1:0] count_next_ext;
    logic [CMPW-1:0] cap_ext;
    logic [CW-1:0]   rd_idx;
    logic [AW-1:0]   wr_addr;
    logic [31:0]     wr_data;

    assign pos_ext        = CMPW'(pos_reg);
    assign idx_ext        = CMPW'(idx_reg);
    assign count_ext      = CMPW'(count_reg);
    assign count_next_ext = CMPW'(count_next);
    assign cap_ext        = CMPW'(cap_reg);

    always_comb
    begin
        stat.op        = op_reg;
        stat.full      = (count_ext >= cap_ext) || (count_ext >= DEPTH_C);
        stat.ins_range = (pos_ext > count_ext);
        stat.del_range = (pos_ext >= count_ext);
        stat.ins_more  = (idx_ext > pos_ext);
        stat.del_more  = ((idx_ext + CMPW'(1)) < count_ext);
        stat.find_more = (idx_ext < count_ext);
        stat.hit       = (rdata_reg == val_reg);
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PREV: rd_idx = idx_reg - CW'(1);
            RD_NEXT: rd_idx = idx_reg + CW'(1);
            default: rd_idx = idx_reg;
        endcase
        if (cmd.wr_val)
        begin
            wr_addr = pos_ext[AW-1:0];
            wr_data = val_reg;
        end
        else
        begin
            wr_addr = idx_reg[AW-1:0];
            wr_data = rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_shift || cmd.wr_val)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= request.opcode;
            pos_reg <= request.position;
            val_reg <= request.value;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_load_count)
        begin
            idx_next = count_reg;
        end
        else if (cmd.idx_load_pos)
        begin
            idx_next = pos_ext[CW-1:0];
        end
        else if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - CW'(1);
        end

        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.res_valid)
        begin
            result_reg.status         <= cmd.res_status;
            result_reg.found_position <= cmd.res_found ? idx_ext[5:0] : 6'd0;
            result_reg.entry_count    <= count_next_ext[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            cap_reg          <= CAP_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= cmd.res_valid;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== tb/sv/pal_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional array list checker
// Watches the request, result and capacity channels of the list, keeps its
// own copy of the list to work out each expected result, and compares every
// result field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module pal_list_checker #(
    parameter int DEPTH = pal_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  pal_pkg::req_t request,
    input  logic          result_valid,
    input  pal_pkg::res_t result,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [6:0]    cfg_data,
    output int            errors,
    output int            pending,
    output int            list_count
);

    import pal_pkg::*;

    logic [31:0] slots [DEPTH];
    int          held;
    logic [6:0]  capacity;
    res_t        due_results [$];
    res_t        want;

    function automatic res_t list_apply(input req_t rq);
        res_t rs;
        int   lim;
        int   i;
        logic hit;
        rs  = '0;
        hit = 1'b0;
        lim = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
        case (rq.opcode)
            OP_INSERT:
            begin
                if (held >= lim)
                    rs.status = ST_FULL;
                else if (int'(rq.position) > held)
                    rs.status = ST_RANGE;
                else
                begin
                    for (i = held; i > int'(rq.position); i--)
                        slots[i] = slots[i - 1];
                    slots[rq.position] = rq.value;
                    held++;
                end
            end
            OP_DELETE:
            begin
                if (int'(rq.position) >= held)
                    rs.status = ST_RANGE;
                else
                begin
                    for (i = int'(rq.position) + 1; i < held; i++)
                        slots[i - 1] = slots[i];
                    held--;
                end
            end
            OP_FIND:
            begin
                for (i = 0; i < held && !hit; i++)
                begin
                    if (slots[i] == rq.value)
                    begin
                        hit               = 1'b1;
                        rs.found_position = 6'(i);
                    end
                end
                if (!hit)
                    rs.status = ST_NOTFOUND;
            end
            default: ;
        endcase
        rs.entry_count = 7'(held);
        return rs;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held     = 0;
            capacity = CAP_RESET;
            errors   = 0;
            due_results.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status mismatch, expected %0d, actual %0d",
                               want.status, result.status);
                        errors++;
                    end
                    if (result.found_position !== want.found_position)
                    begin
                        $error("found_position mismatch, expected %0d, actual %0d",
                               want.found_position, result.found_position);
                        errors++;
                    end
                    if (result.entry_count !== want.entry_count)
                    begin
                        $error("entry_count mismatch, expected %0d, actual %0d",
                               want.entry_count, result.entry_count);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (start && !busy)
                due_results.push_back(list_apply(request));
        end
        pending    = due_results.size();
        list_count = held;
    end

endmodule

// ===== tb/sv/tb_positional_array_list.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional array list testbench
// Resets the list, runs directed requests over the edge cases of insert,
// delete and find, then random request streams under several capacities and
// sender idle rates, and reports the verdict of the attached checker.
// ----------------------------------------------------------------------------
module tb_positional_array_list;

    import pal_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         DRAIN_CYCLES = 140;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       request;
    logic       result_valid;
    res_t       result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;
    int         errors;
    int         pending;
    int         list_count;
    int         idle_pct;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    positional_array_list #(
        .DEPTH(DEPTH_DEFAULT)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .result_valid(result_valid),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    pal_list_checker #(
        .DEPTH(DEPTH_DEFAULT)
    ) list_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .result_valid(result_valid),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .list_count  (list_count)
    );

    task automatic issue(input req_t r);
        @(posedge clk);
        if ($urandom_range(99) < idle_pct)
            repeat ($urandom_range(12, 1)) @(posedge clk);
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        start <= 1'b0;
    endtask

    task automatic put(input logic [1:0] op, input logic [6:0] pos, input logic [31:0] v);
        req_t r;
        r.opcode   = op;
        r.position = pos;
        r.value    = v;
        issue(r);
    endtask

    task automatic drain();
        do @(negedge clk); while (pending != 0 || busy);
    endtask

    task automatic write_capacity(input logic [6:0] cap);
        drain();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t make_request(input int held, input int pct_ins);
        req_t r;
        int   sel;
        sel = $urandom_range(99);
        if (sel < pct_ins)
            r.opcode = OP_INSERT;
        else if (sel < pct_ins + 15)
            r.opcode = OP_FIND;
        else if (sel < pct_ins + 18)
            r.opcode = OP_UNUSED;
        else
            r.opcode = OP_DELETE;
        r.position = 7'($urandom_range(127));
        if ($urandom_range(9) < 8)
        begin
            if (r.opcode == OP_INSERT)
                r.position = 7'($urandom_range(held));
            else if (r.opcode == OP_DELETE && held > 0)
                r.position = 7'($urandom_range(held - 1));
        end
        case ($urandom_range(7))
            0:       r.value = 32'h8000_0000;
            1:       r.value = 32'h7FFF_FFFF;
            2, 3, 4: r.value = int'($urandom_range(15)) - 8;
            default: r.value = $urandom;
        endcase
        return r;
    endfunction

    task automatic random_phase(input int n, input int pct_ins);
        req_t r;
        for (int k = 0; k < n; k++)
        begin
            @(negedge clk);
            r = make_request(list_count, pct_ins);
            issue(r);
            if (k % 50 == 49)
                drain();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        idle_pct  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        put(OP_FIND,   7'd0,   32'd5);
        put(OP_DELETE, 7'd0,   32'd0);
        put(OP_INSERT, 7'd1,   32'd3);
        put(OP_INSERT, 7'd0,   32'h8000_0000);
        put(OP_INSERT, 7'd1,   32'h7FFF_FFFF);
        put(OP_INSERT, 7'd1,   32'hFFFF_FFFF);
        put(OP_INSERT, 7'd0,   32'd7);
        put(OP_INSERT, 7'd4,   32'd7);
        put(OP_INSERT, 7'd127, 32'd9);
        put(OP_INSERT, 7'd6,   32'd9);
        put(OP_FIND,   7'd0,   32'd7);
        put(OP_FIND,   7'd0,   32'h7FFF_FFFF);
        put(OP_FIND,   7'd0,   32'h8000_0000);
        put(OP_FIND,   7'd0,   32'd12345);
        put(OP_FIND,   7'd127, 32'hFFFF_FFFF);
        put(OP_UNUSED, 7'd127, 32'hFFFF_FFFF);
        put(OP_DELETE, 7'd5,   32'd0);
        put(OP_DELETE, 7'd127, 32'd0);
        put(OP_DELETE, 7'd1,   32'd0);
        put(OP_DELETE, 7'd3,   32'd0);
        put(OP_FIND,   7'd0,   32'd7);

        write_capacity(7'd2);
        put(OP_INSERT, 7'd0,   32'd1);
        put(OP_INSERT, 7'd100, 32'd1);
        put(OP_DELETE, 7'd0,   32'd0);
        put(OP_FIND,   7'd0,   32'h7FFF_FFFF);

        write_capacity(7'd0);
        put(OP_INSERT, 7'd0,   32'd1);
        put(OP_FIND,   7'd0,   32'hFFFF_FFFF);

        idle_pct = 37;
        write_capacity(7'd64);
        random_phase(130, 60);
        write_capacity(7'd1);
        random_phase(40, 50);

        idle_pct = 72;
        write_capacity(7'd127);
        random_phase(130, 45);
        write_capacity(7'd5);
        random_phase(40, 50);

        idle_pct = 0;
        write_capacity(7'd64);
        random_phase(100, 30);
        write_capacity(7'($urandom_range(63, 1)));
        random_phase(60, 55);

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/pal_pkg.sv
src/pal_ctrl.sv
src/pal_dp.sv
src/positional_array_list.sv
tb/sv/pal_list_checker.sv
tb/sv/tb_positional_array_list.sv
